### sv/fuzzy_subsequence_scorer_macros.svh
// Assertion shorthands for the scorer. Each expects clk and arst_n in scope.
`ifndef FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH
`define FUZZY_SUBSEQUENCE_SCORER_MACROS_SVH

// Same-cycle implication, silenced while reset is asserted.
`define FSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, silenced while reset is asserted.
`define FSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fss_pkg.sv
package fss_pkg;

	localparam int CHAR_W    = 8;
	localparam int SCORE_W   = 12;
	localparam int PAT_SLOTS = 16;
	localparam int PAT_IDX_W = 4;
	localparam int CFG_W     = 64;
	localparam int PLEN_W    = 5;

	localparam int DEF_MAX_PATTERN_LEN   = 16;
	localparam int DEF_MAX_CANDIDATE_LEN = 4095;

	// scoring weights
	localparam int PTS_BOUNDARY    = 10;
	localparam int PTS_CONSECUTIVE = 5;
	localparam int PTS_PLAIN       = 1;
	localparam int PTS_EXACT_CASE  = 2;
	localparam int LEN_BONUS_BASE  = 50;
	localparam int SCORE_MIN       = -2048;
	localparam int SCORE_PEAK      = 304;

	typedef enum logic [1:0] {
		CFG_PAT_LOW  = 2'd0,
		CFG_PAT_HIGH = 2'd1,
		CFG_PAT_LEN  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic                      char_matched;
		logic                      end_of_candidate;
		logic                      pattern_found;
		logic signed [SCORE_W-1:0] match_score;
	} res_t;

	// fold ASCII upper case onto lower case
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'h20;
		return r;
	endfunction

	function automatic logic is_separator(input logic [CHAR_W-1:0] c);
		return (c == 8'h20) || (c == 8'h3A) || (c == 8'h2F) ||
			(c == 8'h5C) || (c == 8'h5F) || (c == 8'h2D);
	endfunction

endpackage

### sv/fss_in_if.sv
interface fss_in_if;
	import fss_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### sv/fss_out_if.sv
interface fss_out_if;
	import fss_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      char_matched;
	logic                      end_of_candidate;
	logic                      pattern_found;
	logic signed [SCORE_W-1:0] match_score;

	modport source (output valid, output char_matched, output end_of_candidate,
		output pattern_found, output match_score, input ready);
	modport sink   (input valid, input char_matched, input end_of_candidate,
		input pattern_found, input match_score, output ready);
endinterface

### sv/fss_step.sv
module fss_step #(
	parameter int MAX_PATTERN_LEN   = fss_pkg::DEF_MAX_PATTERN_LEN,
	parameter int MAX_CANDIDATE_LEN = fss_pkg::DEF_MAX_CANDIDATE_LEN
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          advance,
	input  logic [fss_pkg::CHAR_W-1:0]                    char_code,
	input  logic                                          last_char,
	input  logic [fss_pkg::PAT_SLOTS-1:0][fss_pkg::CHAR_W-1:0] pattern_chars,
	input  logic [fss_pkg::PLEN_W-1:0]                    pattern_length,
	output fss_pkg::res_t                                 res
);
	import fss_pkg::*;

	localparam int PW = $clog2(MAX_PATTERN_LEN + 1);
	localparam int CW = $clog2(MAX_CANDIDATE_LEN + 1);
	localparam int SW = ((CW > 9) ? CW : 9) + 2;

	logic [PW-1:0] pos_q, pos_d;
	logic          after_sep_q, after_sep_d;
	logic          prev_match_q;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] first_q, first_d;
	logic [CW-1:0] last_q, last_d;
	logic [7:0]    run_q, run_d;

	logic [PW-1:0]        len_act;
	logic [CHAR_W-1:0]    pchar;
	logic [CHAR_W-1:0]    lc;
	logic                 matched;
	logic [7:0]           pts;
	logic [CW:0]          cand_len;
	logic [5:0]           bonus;
	logic [CW-1:0]        span;
	logic signed [SW-1:0] score_w;
	logic                 found;

	always_comb begin
		len_act = (pattern_length > PLEN_W'(MAX_PATTERN_LEN)) ?
			PW'(MAX_PATTERN_LEN) : PW'(pattern_length);
		pchar   = pattern_chars[PAT_IDX_W'(pos_q)];
		lc      = fold_case(char_code);
		matched = (pos_q < len_act) && (lc == fold_case(pchar));

		if (after_sep_q)
			pts = 8'(PTS_BOUNDARY);
		else if (prev_match_q)
			pts = 8'(PTS_CONSECUTIVE);
		else
			pts = 8'(PTS_PLAIN);
		if (char_code == pchar)
			pts = pts + 8'(PTS_EXACT_CASE);

		run_d   = run_q;
		first_d = first_q;
		last_d  = last_q;
		pos_d   = pos_q;
		if (matched) begin
			run_d  = run_q + pts;
			if (pos_q == '0)
				first_d = idx_q;
			last_d = idx_q;
			pos_d  = pos_q + 1'b1;
		end
		after_sep_d = is_separator(lc);

		// verdict on the updated per-candidate state
		cand_len = (CW+1)'(idx_q) + 1'b1;
		bonus    = (cand_len < (CW+1)'(LEN_BONUS_BASE)) ?
			6'((CW+1)'(LEN_BONUS_BASE) - cand_len) : 6'd0;
		span     = last_d - first_d;
		score_w  = $signed(SW'(run_d)) + $signed(SW'(bonus)) -
			$signed(SW'(span[CW-1:1]));
		found    = (len_act == '0) || (pos_d >= len_act);

		idx_d = idx_q;
		if (idx_q < CW'(MAX_CANDIDATE_LEN))
			idx_d = idx_q + 1'b1;

		res.char_matched     = matched;
		res.end_of_candidate = last_char;
		res.pattern_found    = last_char && found;
		res.match_score      = '0;
		if (last_char && found && len_act != '0) begin
			if (score_w < $signed(SW'(SCORE_MIN)))
				res.match_score = SCORE_W'(SCORE_MIN);
			else
				res.match_score = SCORE_W'(score_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			after_sep_q  <= 1'b1;
			prev_match_q <= 1'b0;
			idx_q        <= '0;
			first_q      <= '0;
			last_q       <= '0;
			run_q        <= '0;
		end else if (advance) begin
			if (last_char) begin
				// drop all per-candidate state for the next string
				pos_q        <= '0;
				after_sep_q  <= 1'b1;
				prev_match_q <= 1'b0;
				idx_q        <= '0;
				first_q      <= '0;
				last_q       <= '0;
				run_q        <= '0;
			end else begin
				pos_q        <= pos_d;
				after_sep_q  <= after_sep_d;
				prev_match_q <= matched;
				idx_q        <= idx_d;
				first_q      <= first_d;
				last_q       <= last_d;
				run_q        <= run_d;
			end
		end
	end

endmodule

### sv/fuzzy_subsequence_scorer.sv
// Fuzzy subsequence scorer: streams a candidate string one character word at a
// time against a pattern of up to MAX_PATTERN_LEN characters held in three
// configuration registers (low chars, high chars, length; write only while the
// block is idle). Matching is greedy, ASCII case-insensitive, and every word
// returns one result word: char_matched flags a highlight position, and on the
// word marked last_char the verdict (pattern_found, signed match_score) is
// given and per-candidate state returns to its reset value. Throughput is one
// character per cycle while the result side is not stalled; each accepted
// character passes through the input register and then through the
// per-character step logic into the result register. The character position
// saturates at MAX_CANDIDATE_LEN. No clearing pass is needed after reset.
`include "fuzzy_subsequence_scorer_macros.svh"

module fuzzy_subsequence_scorer #(
	parameter int MAX_PATTERN_LEN   = fss_pkg::DEF_MAX_PATTERN_LEN,
	parameter int MAX_CANDIDATE_LEN = fss_pkg::DEF_MAX_CANDIDATE_LEN
) (
	input  logic                      clk,
	input  logic                      arst_n,
	fss_in_if.sink                    char_in,
	fss_out_if.source                 result_out,
	input  logic                      cfg_wen,
	input  logic [1:0]                cfg_index,
	input  logic [fss_pkg::CFG_W-1:0] cfg_wdata
);
	import fss_pkg::*;

	// configuration registers
	logic [CFG_W-1:0]  pat_low_q;
	logic [CFG_W-1:0]  pat_high_q;
	logic [PLEN_W-1:0] pat_len_q;

	// input register stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_code_s1;
	logic              last_char_s1;

	// result register stage
	logic valid_s2;
	res_t res_s2;
	res_t res_step;

	logic advance;

	// advance the input stage whenever the result register is free or drains
	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign char_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PAT_LOW:  pat_low_q  <= cfg_wdata;
				CFG_PAT_HIGH: pat_high_q <= cfg_wdata;
				CFG_PAT_LEN:  pat_len_q  <= cfg_wdata[PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (char_in.ready)
			valid_s1 <= char_in.valid;
	end

	// payload holds while the stage is stalled
	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			char_code_s1 <= char_in.char_code;
			last_char_s1 <= char_in.last_char;
		end
	end

	fss_step #(
		.MAX_PATTERN_LEN   (MAX_PATTERN_LEN),
		.MAX_CANDIDATE_LEN (MAX_CANDIDATE_LEN)
	) u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.char_code      (char_code_s1),
		.last_char      (last_char_s1),
		.pattern_chars  ({pat_high_q, pat_low_q}),
		.pattern_length (pat_len_q),
		.res            (res_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (result_out.ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_step;
	end

	assign result_out.valid            = valid_s2;
	assign result_out.char_matched     = res_s2.char_matched;
	assign result_out.end_of_candidate = res_s2.end_of_candidate;
	assign result_out.pattern_found    = res_s2.pattern_found;
	assign result_out.match_score      = res_s2.match_score;

	// a verdict only ever rides on the last character of a candidate
	`FSS_ASSERT_IMP(a_found_at_end, valid_s2 && res_s2.pattern_found, res_s2.end_of_candidate, "verdict on a non-final word")

	// mid-string words carry a zero score
	`FSS_ASSERT_IMP(a_score_zero_mid, valid_s2 && !res_s2.end_of_candidate, res_s2.match_score == '0, "score on a mid-string word")

	// the running score plus the length bonus bounds the verdict from above
	`FSS_ASSERT_IMP(a_score_peak, valid_s2, res_s2.match_score <= $signed(SCORE_W'(SCORE_PEAK)), "score above its ceiling")

	// a stalled result never loses a word: the input stage must hold too
	`FSS_ASSERT_NXT(a_stall_holds, valid_s1 && valid_s2 && !result_out.ready, valid_s1 && valid_s2, "word lost under stall")

endmodule

### sim/fuzzy_subsequence_scorer_tb.sv
module fuzzy_subsequence_scorer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fss_pkg::*;

	// Index with no register behind it: the block must ignore writes to it.
	localparam logic [1:0] CFG_SPARE = 2'd3;

	localparam int RANDOM_WORDS = 1300;
	localparam int LONG_HOLD    = 300;
	localparam int LONG_CAND    = 600;
	localparam int SCORE_TOP    = 2047;

	typedef enum logic {
		ROW_REG,
		ROW_CHAR
	} row_kind_t;

	// One line of the directed table: a register write or a character word,
	// optionally with its result typed in by hand.
	typedef struct {
		row_kind_t   kind;
		logic [1:0]  idx;
		logic [63:0] data;
		logic [7:0]  ch;
		logic        is_last;
		logic        typed;
		res_t        want;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	fss_in_if  char_in ();
	fss_out_if result_out ();

	fuzzy_subsequence_scorer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.result_out (result_out),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the scorer: configuration and per-candidate state
	// ------------------------------------------------------------------
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [4:0]  pat_len;

	logic [4:0]  pat_pos;
	logic        after_sep;
	logic        prev_hit;
	logic [11:0] char_idx;
	logic [11:0] first_pos;
	logic [11:0] last_pos;
	logic [7:0]  run_score;

	// Scores still owed by the block, oldest first.
	res_t pending_scores[$];
	int   mismatches = 0;
	int   result_no  = 0;

	// Knobs shared between the stimulus and the receiving side.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int holds_wanted = 0;

	logic [7:0] cand[$];

	function automatic void clear_candidate();
		pat_pos   = '0;
		after_sep = 1'b1;
		prev_hit  = 1'b0;
		char_idx  = '0;
		first_pos = '0;
		last_pos  = '0;
		run_score = '0;
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
	endfunction

	function automatic logic boundary_char(logic [7:0] c);
		case (c)
			" ", ":", "/", "\\", "_", "-": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [7:0] pattern_at(int unsigned i);
		return (i < 8) ? pat_lo[i*8 +: 8] : pat_hi[(i-8)*8 +: 8];
	endfunction

	// Lengths above the slot count behave as a full pattern.
	function automatic int unsigned live_len();
		return (pat_len > DEF_MAX_PATTERN_LEN) ? DEF_MAX_PATTERN_LEN : pat_len;
	endfunction

	// Advance the shadow state by one character and return the result word.
	function automatic res_t score_char(logic [7:0] c, logic is_last);
		res_t        r;
		int unsigned plen;
		logic        hit;
		int          total;
		int          span;
		int          cand_len;
		plen = live_len();
		hit  = 1'b0;
		r    = '0;
		if (pat_pos < plen) begin
			if (lower(c) == lower(pattern_at(pat_pos))) begin
				hit = 1'b1;
				if (after_sep)
					run_score = run_score + 8'(PTS_BOUNDARY);
				else if (prev_hit)
					run_score = run_score + 8'(PTS_CONSECUTIVE);
				else
					run_score = run_score + 8'(PTS_PLAIN);
				if (c == pattern_at(pat_pos))
					run_score = run_score + 8'(PTS_EXACT_CASE);
				if (pat_pos == 0)
					first_pos = char_idx;
				last_pos = char_idx;
				pat_pos  = pat_pos + 5'd1;
			end
		end
		after_sep = boundary_char(lower(c));
		prev_hit  = hit;
		if (is_last) begin
			if (plen == 0) begin
				r.pattern_found = 1'b1;
			end else if (pat_pos >= plen) begin
				cand_len = char_idx + 1;
				span     = last_pos - first_pos;
				total    = run_score;
				if (cand_len < LEN_BONUS_BASE)
					total += LEN_BONUS_BASE - cand_len;
				total -= span / 2;
				if (total < SCORE_MIN)
					total = SCORE_MIN;
				if (total > SCORE_TOP)
					total = SCORE_TOP;
				r.pattern_found = 1'b1;
				r.match_score   = total[SCORE_W-1:0];
			end
			clear_candidate();
		end else if (char_idx < DEF_MAX_CANDIDATE_LEN) begin
			char_idx = char_idx + 12'd1;
		end
		r.char_matched     = hit;
		r.end_of_candidate = is_last;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Directed table rows
	// ------------------------------------------------------------------
	function automatic row_t reg_row(logic [1:0] idx, logic [63:0] data);
		row_t r;
		r = '{ROW_REG, idx, data, 8'h00, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t char_row(logic [7:0] c, logic is_last);
		row_t r;
		r = '{ROW_CHAR, 2'd0, 64'd0, c, is_last, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t known_row(logic [7:0] c, logic is_last, logic m, logic f,
			logic signed [SCORE_W-1:0] s);
		row_t r;
		r = '{ROW_CHAR, 2'd0, 64'd0, c, is_last, 1'b1, '0};
		r.want.char_matched     = m;
		r.want.end_of_candidate = is_last;
		r.want.pattern_found    = f;
		r.want.match_score      = s;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------
	function automatic logic [7:0] sep_code(int k);
		case (k)
			0: return " ";
			1: return ":";
			2: return "/";
			3: return "\\";
			4: return "_";
			default: return "-";
		endcase
	endfunction

	// Candidate filler: mostly letters, plus separators and arbitrary bytes.
	function automatic logic [7:0] noise_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 8'($urandom_range("a", "z"));
		else if (r < 55)
			return 8'($urandom_range("A", "Z"));
		else if (r < 70)
			return sep_code($urandom_range(0, 5));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pattern_pick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 8'($urandom_range("a", "z"));
		else if (r < 75)
			return 8'($urandom_range("A", "Z"));
		else if (r < 85)
			return (r < 80) ? sep_code($urandom_range(0, 5)) : 8'($urandom_range("0", "9"));
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Fill cand with one candidate string. Most carry the pattern as a
	// subsequence with noise between; some drop a pattern character, the
	// rest are plain noise.
	function automatic void build_candidate();
		int unsigned plen;
		int          drop;
		int          pad;
		logic [7:0]  c;
		plen = live_len();
		cand.delete();
		if (plen > 0 && $urandom_range(0, 9) < 7) begin
			drop = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, plen - 1)) : -1;
			for (int i = 0; i < plen; i++) begin
				pad = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 4)) : 0;
				repeat (pad) cand.insert(cand.size(), noise_char());
				if (i != drop) begin
					c = pattern_at(i);
					if (is_letter(c) && $urandom_range(0, 9) < 3)
						c = c ^ 8'h20;
					cand.insert(cand.size(), c);
				end
			end
			// a long tail now and then takes the length past the bonus cut-off
			pad = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 3))
				: int'($urandom_range(10, 45));
			repeat (pad) cand.insert(cand.size(), noise_char());
		end else begin
			repeat ($urandom_range(1, 30)) cand.insert(cand.size(), noise_char());
		end
		if (cand.size() == 0)
			cand.insert(cand.size(), noise_char());
	endfunction

	// Sender gap: mostly none, some short, a few long.
	function automatic int tx_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------
	// Driving tasks; each is entered and left at a falling edge
	// ------------------------------------------------------------------
	task automatic reg_write(logic [1:0] idx, logic [63:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
		case (idx)
			CFG_PAT_LOW:  pat_lo  = data;
			CFG_PAT_HIGH: pat_hi  = data;
			CFG_PAT_LEN:  pat_len = data[PLEN_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one character word, hold it until taken, then book its result.
	task automatic send_word(logic [7:0] c, logic is_last, logic typed, res_t want);
		int   gap;
		res_t guess;
		gap = tx_gap();
		if (gap > 0) begin
			char_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		char_in.valid     <= 1'b1;
		char_in.char_code <= c;
		char_in.last_char <= is_last;
		do @(posedge clk); while (char_in.ready !== 1'b1);
		guess = score_char(c, is_last);
		pending_scores.insert(pending_scores.size(), typed ? want : guess);
		@(negedge clk);
	endtask

	// Stop offering and let every owed result drain, plus the pipeline depth.
	task automatic wait_idle();
		char_in.valid <= 1'b0;
		while (pending_scores.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic new_pattern();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;
		int          r;
		for (int i = 0; i < 8; i++) begin
			lo[i*8 +: 8] = pattern_pick();
			hi[i*8 +: 8] = pattern_pick();
		end
		len_word = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 5)
			len_word[4:0] = 5'd0;
		else if (r < 15)
			len_word[4:0] = 5'(DEF_MAX_PATTERN_LEN);
		else if (r < 20)
			len_word[4:0] = 5'($urandom_range(17, 31));
		else if (r < 85)
			len_word[4:0] = 5'($urandom_range(1, 8));
		else
			len_word[4:0] = 5'($urandom_range(9, 15));
		reg_write(CFG_PAT_LOW, lo);
		reg_write(CFG_PAT_HIGH, hi);
		reg_write(CFG_PAT_LEN, len_word);
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		mismatches++;
		$display("[%0t] result %0d: %s got %0d expected %0d",
			$realtime, result_no, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Receiving side: random back-pressure, plus the long hold on request
	// ------------------------------------------------------------------
	initial begin : result_sink
		int n;
		int holds_done;
		int r;
		holds_done = 0;
		result_out.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (holds_done != holds_wanted) begin
				// drop ready and count the hold out here, whatever the sender does
				holds_done++;
				result_out.ready <= 1'b0;
				n = LONG_HOLD;
			end else if (rx_steady) begin
				result_out.ready <= 1'b1;
				n = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					result_out.ready <= 1'b1;
					n = $urandom_range(1, 8);
				end else if (r < 95) begin
					result_out.ready <= 1'b0;
					n = $urandom_range(1, 3);
				end else begin
					result_out.ready <= 1'b0;
					n = $urandom_range(10, 40);
				end
			end
			repeat (n) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: compare each accepted word with the oldest booking
	// ------------------------------------------------------------------
	initial begin : result_check
		res_t got;
		res_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_out.valid === 1'b1 && result_out.ready === 1'b1) begin
				got.char_matched     = result_out.char_matched;
				got.end_of_candidate = result_out.end_of_candidate;
				got.pattern_found    = result_out.pattern_found;
				got.match_score      = result_out.match_score;
				if (pending_scores.size() == 0) begin
					flag_mismatch("unbooked result, score", got.match_score, 0);
				end else begin
					want = pending_scores.pop_front();
					if (got.char_matched !== want.char_matched)
						flag_mismatch("char_matched", got.char_matched, want.char_matched);
					if (got.end_of_candidate !== want.end_of_candidate)
						flag_mismatch("end_of_candidate", got.end_of_candidate,
							want.end_of_candidate);
					if (got.pattern_found !== want.pattern_found)
						flag_mismatch("pattern_found", got.pattern_found, want.pattern_found);
					if (got.match_score !== want.match_score)
						flag_mismatch("match_score", got.match_score, want.match_score);
				end
				result_no++;
			end
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("fuzzy_subsequence_scorer regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		row_t plan[$];
		int   sent_random;
		int   phase;
		int   ncand;
		bit   cut;

		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		char_in.valid     = 1'b0;
		char_in.char_code = '0;
		char_in.last_char = 1'b0;
		pat_lo  = '0;
		pat_hi  = '0;
		pat_len = '0;
		clear_candidate();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part. Straight after reset the pattern is empty: every
		// candidate is found with score zero and nothing matches.
		plan.insert(plan.size(), known_row(8'h00, 1'b0, 1'b0, 1'b0, 12'sd0));
		plan.insert(plan.size(), known_row(8'hFF, 1'b1, 1'b0, 1'b1, 12'sd0));
		// single "a": boundary 10, exact case 2, length bonus 49
		plan.insert(plan.size(), reg_row(CFG_PAT_LOW, 64'h0000_0000_0000_6261));
		plan.insert(plan.size(), reg_row(CFG_PAT_LEN, 64'd1));
		plan.insert(plan.size(), known_row("a", 1'b1, 1'b1, 1'b1, 12'sd61));
		// "ab", with junk above the length field; a miss scores nothing
		plan.insert(plan.size(), reg_row(CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE2));
		plan.insert(plan.size(), known_row("x", 1'b1, 1'b0, 1'b0, 12'sd0));
		// folded case, then a consecutive hit
		plan.insert(plan.size(), char_row("A", 1'b0));
		plan.insert(plan.size(), char_row("b", 1'b0));
		plan.insert(plan.size(), char_row("z", 1'b1));
		// every separator ahead of a hit or between hits
		plan.insert(plan.size(), char_row(" ", 1'b0));
		plan.insert(plan.size(), char_row("a", 1'b0));
		plan.insert(plan.size(), char_row("/", 1'b0));
		plan.insert(plan.size(), char_row("b", 1'b1));
		plan.insert(plan.size(), char_row(":", 1'b0));
		plan.insert(plan.size(), char_row("A", 1'b0));
		plan.insert(plan.size(), char_row("\\", 1'b0));
		plan.insert(plan.size(), char_row("_", 1'b0));
		plan.insert(plan.size(), char_row("B", 1'b1));
		plan.insert(plan.size(), char_row("-", 1'b0));
		plan.insert(plan.size(), char_row("a", 1'b0));
		// shorten the pattern mid-candidate: one hit already covers it
		plan.insert(plan.size(), reg_row(CFG_PAT_LEN, 64'd1));
		plan.insert(plan.size(), char_row("q", 1'b1));
		// spare index, then all-ones pattern with an oversized length
		plan.insert(plan.size(), reg_row(CFG_SPARE, {64{1'b1}}));
		plan.insert(plan.size(), reg_row(CFG_PAT_LOW, {64{1'b1}}));
		plan.insert(plan.size(), reg_row(CFG_PAT_HIGH, {64{1'b1}}));
		plan.insert(plan.size(), reg_row(CFG_PAT_LEN, 64'd31));
		plan.insert(plan.size(), char_row(8'hFF, 1'b0));
		plan.insert(plan.size(), char_row(8'hFE, 1'b0));
		plan.insert(plan.size(), char_row(8'hFF, 1'b1));
		// back to the empty pattern
		plan.insert(plan.size(), reg_row(CFG_PAT_LEN, 64'd0));
		plan.insert(plan.size(), reg_row(CFG_PAT_HIGH, 64'd0));
		plan.insert(plan.size(), reg_row(CFG_PAT_LOW, 64'd0));
		plan.insert(plan.size(), known_row("a", 1'b1, 1'b0, 1'b1, 12'sd0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				wait_idle();
				reg_write(plan[i].idx, plan[i].data);
			end else begin
				send_word(plan[i].ch, plan[i].is_last, plan[i].typed, plan[i].want);
			end
		end

		// Random part: each phase drains, loads a fresh pattern and streams
		// a handful of candidates. A phase may end mid-candidate so the next
		// pattern lands on half-consumed state.
		sent_random = 0;
		phase = 0;
		while (sent_random < RANDOM_WORDS) begin
			wait_idle();
			new_pattern();
			tx_steady = ($urandom_range(0, 5) == 0);
			rx_steady = ($urandom_range(0, 5) == 0);
			if (phase == 2 || phase == 40) begin
				// keep offering while the receiver holds off, so the block backs up
				tx_steady = 1'b1;
				holds_wanted++;
			end
			ncand = $urandom_range(3, 10);
			for (int k = 0; k < ncand; k++) begin
				build_candidate();
				cut = (k == ncand - 1) && ($urandom_range(0, 3) == 0);
				foreach (cand[j])
					send_word(cand[j], (j == cand.size() - 1) && !cut, 1'b0, '0);
				sent_random += cand.size();
				// now and then let everything owed come back before going on
				if ($urandom_range(0, 9) == 0)
					wait_idle();
			end
			phase++;
		end

		// One long candidate: no length bonus, and the span penalty drives
		// the score well below zero.
		wait_idle();
		reg_write(CFG_PAT_LOW, 64'h0000_0000_0000_6261);
		reg_write(CFG_PAT_LEN, 64'd2);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		send_word("a", 1'b0, 1'b0, '0);
		repeat (LONG_CAND - 2) send_word("x", 1'b0, 1'b0, '0);
		send_word("b", 1'b1, 1'b0, '0);

		wait_idle();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("fuzzy_subsequence_scorer regression: pass");
		else
			$display("fuzzy_subsequence_scorer regression: fail");
		$finish;
	end

endmodule
